FILE: hdl/first_match_ternary_guard_table_top_macros.svh
// Assertion helpers for the guard table block.
// Each macro expects clk and rst_n in scope and is switched off while in reset.
`ifndef FIRST_MATCH_TERNARY_GUARD_TABLE_TOP_MACROS_SVH
`define FIRST_MATCH_TERNARY_GUARD_TABLE_TOP_MACROS_SVH

// Same-cycle implication.
`define FMTGT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FMTGT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/fmtgt_pkg.sv
`default_nettype none

package fmtgt_pkg;

    // Table geometry.
    localparam int MAX_ENTRIES = 256;
    localparam int KEY_BITS    = 5;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int VARIANT_W   = 8;
    localparam int ENTRY_W     = 2 * KEY_BITS + VARIANT_W;

    // Result cost counter.
    localparam int COST_W   = 11;
    localparam int STEP_W   = 3;
    localparam int COST_MAX = 2047;

    // Configuration port.
    localparam int CFG_COUNT_W = 9;
    localparam int DATA_W      = 32;
    localparam int PADDR_W     = 3;

    // Register indexes.
    localparam logic CFG_ENTRY_COUNT = 1'b0;
    localparam logic CFG_FALLBACK    = 1'b1;

    // Item function codes.
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // Input word.
    typedef struct packed {
        logic                 func;
        logic [7:0]           entry_index;
        logic [KEY_BITS-1:0]  care_mask;
        logic [KEY_BITS-1:0]  care_values;
        logic [VARIANT_W-1:0] entry_variant;
        logic [KEY_BITS-1:0]  fact_key;
    } item_t;

    // Result word.
    typedef struct packed {
        logic [VARIANT_W-1:0] chosen_variant;
        logic                 used_fallback;
        logic [COST_W-1:0]    step_cost;
    } result_t;

    // One stored guard entry.
    typedef struct packed {
        logic [KEY_BITS-1:0]  care_mask;
        logic [KEY_BITS-1:0]  care_values;
        logic [VARIANT_W-1:0] variant;
    } entry_t;

    // Outcome of checking one entry against a key.
    typedef struct packed {
        logic              hit;
        logic [STEP_W-1:0] steps;
    } check_t;

    // Walk the cared bits from bit 0 upward, stopping at the first mismatch.
    function automatic check_t check_entry(input logic [KEY_BITS-1:0] mask,
                                           input logic [KEY_BITS-1:0] vals,
                                           input logic [KEY_BITS-1:0] key);
        check_t r;
        logic   stop;
        int     d;
        r.hit   = 1'b1;
        r.steps = STEP_W'(1);
        stop    = 1'b0;
        for (d = 0; d < KEY_BITS; d++) begin
            if (!stop && mask[d]) begin
                r.steps = r.steps + STEP_W'(1);
                if (key[d] != vals[d]) begin
                    r.hit = 1'b0;
                    stop  = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // Saturating add of a small step count to the running cost.
    function automatic logic [COST_W-1:0] cost_add(input logic [COST_W-1:0] a,
                                                   input logic [STEP_W:0]   b);
        logic [COST_W:0] s;
        s = {1'b0, a} + (COST_W+1)'(b);
        if (s > (COST_W+1)'(COST_MAX)) begin
            return COST_W'(COST_MAX);
        end
        return s[COST_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/first_match_ternary_guard_table_top.sv
// Write word: taken while idle, the next word may follow in the next cycle; gives no result.
// Lookup over n entries in use (n capped at the table size): entries are read in order and
// checked as they return, stopping at the first hit; on a miss or an empty table the fallback
// answers. One lookup at a time: the next word is taken once the result word is written out,
// later while an earlier result word is held by result_stall.
// Reset (rst_n, asynchronous, active low) clears the sequencer, output and both registers.
`default_nettype none

module first_match_ternary_guard_table_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Input words.
    input  wire logic                            item_valid,
    output      logic                            item_stall,
    input  wire fmtgt_pkg::item_t                item,
    // Result words.
    output      logic                            result_valid,
    input  wire logic                            result_stall,
    output      fmtgt_pkg::result_t              result,
    // Configuration port.
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [fmtgt_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [fmtgt_pkg::DATA_W-1:0]    pwdata,
    output      logic [fmtgt_pkg::DATA_W-1:0]    prdata,
    output      logic                            pready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t                                state_reg, state_next;
    logic [fmtgt_pkg::CNT_W-1:0]           n_reg, n_next;
    logic [fmtgt_pkg::CNT_W-1:0]           iss_reg, iss_next;
    logic                                  rv_reg, rv_next;
    logic [fmtgt_pkg::COST_W-1:0]          cost_reg, cost_next;
    logic [fmtgt_pkg::KEY_BITS-1:0]        key_reg, key_next;
    fmtgt_pkg::result_t                    pend_reg, pend_next;
    fmtgt_pkg::result_t                    res_reg, res_next;
    logic                                  result_valid_reg, result_valid_next;
    logic [fmtgt_pkg::CFG_COUNT_W-1:0]     cfg_count_reg, cfg_count_next;
    logic [fmtgt_pkg::VARIANT_W-1:0]       cfg_fallback_reg, cfg_fallback_next;

    logic                                  cfg_wr;
    logic                                  cfg_sel;
    logic [fmtgt_pkg::CNT_W-1:0]           n_clamp;
    logic                                  ram_we;
    logic                                  rd_en;
    logic [fmtgt_pkg::ENTRY_W-1:0]         ram_wdata;
    logic [fmtgt_pkg::ENTRY_W-1:0]         ram_rdata;
    fmtgt_pkg::entry_t                     ent;
    fmtgt_pkg::check_t                     chk;
    logic [fmtgt_pkg::COST_W-1:0]          cost_after;
    logic                                  emit_go;

    // Guard table storage.
    fmtgt_ram #(
        .WIDTH (fmtgt_pkg::ENTRY_W),
        .DEPTH (fmtgt_pkg::MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fmtgt_pkg::ADDR_W'(item.entry_index)),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (iss_reg[fmtgt_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign ram_wdata = {item.care_mask, item.care_values, item.entry_variant};

    // Configuration port decode and read-back.
    assign pready  = 1'b1;
    assign cfg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        unique case (cfg_sel)
            fmtgt_pkg::CFG_ENTRY_COUNT: prdata = fmtgt_pkg::DATA_W'(cfg_count_reg);
            fmtgt_pkg::CFG_FALLBACK:    prdata = fmtgt_pkg::DATA_W'(cfg_fallback_reg);
            default:                    prdata = '0;
        endcase
    end

    // The scan never runs beyond the table.
    always_comb
    begin
        if (int'(cfg_count_reg) > fmtgt_pkg::MAX_ENTRIES)
        begin
            n_clamp = fmtgt_pkg::CNT_W'(fmtgt_pkg::MAX_ENTRIES);
        end
        else
        begin
            n_clamp = fmtgt_pkg::CNT_W'(cfg_count_reg);
        end
    end

    // Shared check unit: one entry per cycle against the held key.
    assign ent        = fmtgt_pkg::entry_t'(ram_rdata);
    assign chk        = fmtgt_pkg::check_entry(ent.care_mask, ent.care_values, key_reg);
    assign cost_after = fmtgt_pkg::cost_add(cost_reg, {1'b0, chk.steps});
    assign emit_go    = !result_valid_reg || !result_stall;

    // Sequencer next-state logic. The answer waits in its own register so that a
    // result word held by the receiver is left untouched.
    always_comb
    begin
        state_next        = state_reg;
        n_next            = n_reg;
        iss_next          = iss_reg;
        rv_next           = 1'b0;
        cost_next         = cost_reg;
        key_next          = key_reg;
        pend_next         = pend_reg;
        res_next          = res_reg;
        result_valid_next = result_valid_reg && result_stall;
        cfg_count_next    = cfg_count_reg;
        cfg_fallback_next = cfg_fallback_reg;
        ram_we            = 1'b0;
        rd_en             = 1'b0;

        if (cfg_wr)
        begin
            unique case (cfg_sel)
                fmtgt_pkg::CFG_ENTRY_COUNT:
                    cfg_count_next = pwdata[fmtgt_pkg::CFG_COUNT_W-1:0];
                fmtgt_pkg::CFG_FALLBACK:
                    cfg_fallback_next = pwdata[fmtgt_pkg::VARIANT_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.func == fmtgt_pkg::FUNC_LOOKUP)
                    begin
                        key_next  = item.fact_key;
                        n_next    = n_clamp;
                        iss_next  = '0;
                        cost_next = '0;
                        if (n_clamp == '0)
                        begin
                            // Empty table: straight to the fallback answer.
                            pend_next.chosen_variant = cfg_fallback_reg;
                            pend_next.used_fallback  = 1'b1;
                            pend_next.step_cost      = fmtgt_pkg::COST_W'(1);
                            state_next               = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        ram_we = int'(item.entry_index) < fmtgt_pkg::MAX_ENTRIES;
                    end
                end
            end

            S_SCAN:
            begin
                // Issue the next read while the previous entry is checked.
                rd_en = iss_reg < n_reg;
                if (rd_en)
                begin
                    iss_next = iss_reg + fmtgt_pkg::CNT_W'(1);
                end
                rv_next = rd_en;
                if (rv_reg)
                begin
                    if (chk.hit)
                    begin
                        pend_next.chosen_variant = ent.variant;
                        pend_next.used_fallback  = 1'b0;
                        pend_next.step_cost      = cost_after;
                        rv_next                  = 1'b0;
                        state_next               = S_EMIT;
                    end
                    else if (!rd_en)
                    begin
                        // Last entry missed as well.
                        pend_next.chosen_variant = cfg_fallback_reg;
                        pend_next.used_fallback  = 1'b1;
                        pend_next.step_cost      = fmtgt_pkg::cost_add(cost_after,
                                                       (fmtgt_pkg::STEP_W+1)'(1));
                        state_next               = S_EMIT;
                    end
                    else
                    begin
                        cost_next = cost_after;
                    end
                end
            end

            S_EMIT:
            begin
                if (emit_go)
                begin
                    res_next          = pend_reg;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, counters, configuration and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            n_reg            <= '0;
            iss_reg          <= '0;
            rv_reg           <= 1'b0;
            cost_reg         <= '0;
            key_reg          <= '0;
            pend_reg         <= '0;
            res_reg          <= '0;
            result_valid_reg <= 1'b0;
            cfg_count_reg    <= '0;
            cfg_fallback_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            n_reg            <= n_next;
            iss_reg          <= iss_next;
            rv_reg           <= rv_next;
            cost_reg         <= cost_next;
            key_reg          <= key_next;
            pend_reg         <= pend_next;
            res_reg          <= res_next;
            result_valid_reg <= result_valid_next;
            cfg_count_reg    <= cfg_count_next;
            cfg_fallback_reg <= cfg_fallback_next;
        end
    end

    // Outputs.
    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = res_reg;

    // Checks.
`include "first_match_ternary_guard_table_top_macros.svh"

    `FMTGT_ASSERT_NOW(a_rv_in_scan, rv_reg, state_reg == S_SCAN,
        "Read data marked valid outside the scan.")
    `FMTGT_ASSERT_NEXT(a_iss_step, (state_reg == S_SCAN) && rd_en,
        iss_reg == ($past(iss_reg) + fmtgt_pkg::CNT_W'(1)),
        "Scan pointer did not advance after a read.")
    `FMTGT_ASSERT_NOW(a_new_result_from_emit, $rose(result_valid_reg),
        $past(state_reg == S_EMIT),
        "Result word appeared without an emit step.")
    `FMTGT_ASSERT_NOW(a_cost_nonzero, result_valid_reg, res_reg.step_cost != '0,
        "Result word carries a zero step cost.")

endmodule

`default_nettype wire

FILE: hdl/fmtgt_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module fmtgt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: bench/first_match_ternary_guard_table_top_test.sv
module first_match_ternary_guard_table_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEEP          = -1;
    localparam int SETTLE_CYCLES = 300;
    localparam int PHASES        = 10;
    localparam int PHASE_WORDS   = 150;
    localparam int DEEP_WORDS    = 24;
    localparam int PROBE_ROWS    = 17;

    // One row of the directed part: register settings applied before the word
    // (KEEP leaves a register alone) and, for some lookups, a typed-in answer.
    typedef struct packed {
        int                 new_count;
        int                 new_miss;
        fmtgt_pkg::item_t   word;
        logic               known;
        fmtgt_pkg::result_t answer;
    } probe_t;

    localparam fmtgt_pkg::result_t NO_RESULT = '0;

    localparam probe_t PROBES [PROBE_ROWS] = '{
        // Lookups straight after reset: empty table, fallback 0.
        '{KEEP, KEEP, '{fmtgt_pkg::FUNC_LOOKUP, 8'h00, 5'h00, 5'h00, 8'h00, 5'h00},
          1'b1, '{8'h00, 1'b1, 11'd1}},
        '{KEEP, KEEP, '{fmtgt_pkg::FUNC_LOOKUP, 8'hFF, 5'h1F, 5'h1F, 8'hFF, 5'h1F},
          1'b1, '{8'h00, 1'b1, 11'd1}},
        // A small table: exact all-ones, exact all-zeros, top bit only, catch-all.
        '{KEEP, KEEP, '{fmtgt_pkg::FUNC_WRITE, 8'h00, 5'h1F, 5'h1F, 8'hFF, 5'h1F},
          1'b0, NO_RESULT},
        '{KEEP, KEEP, '{fmtgt_pkg::FUNC_WRITE, 8'h01, 5'h1F, 5'h00, 8'h00, 5'h00},
          1'b0, NO_RESULT},
        '{KEEP, KEEP, '{fmtgt_pkg::FUNC_WRITE, 8'h02, 5'h10, 5'h10, 8'h80, 5'h0A},
          1'b0, NO_RESULT},
        '{KEEP, KEEP, '{fmtgt_pkg::FUNC_WRITE, 8'h03, 5'h00, 5'h1F, 8'h3C, 5'h15},
          1'b0, NO_RESULT},
        '{KEEP, KEEP, '{fmtgt_pkg::FUNC_WRITE, 8'hFF, 5'h0A, 5'h15, 8'h01, 5'h1F},
          1'b0, NO_RESULT},
        // One entry in use: a full hit, then misses at the first and last bit.
        '{1, 255, '{fmtgt_pkg::FUNC_LOOKUP, 8'h00, 5'h00, 5'h00, 8'h00, 5'h1F},
          1'b1, '{8'hFF, 1'b0, 11'd6}},
        '{KEEP, KEEP, '{fmtgt_pkg::FUNC_LOOKUP, 8'h55, 5'h0A, 5'h15, 8'hAA, 5'h1E},
          1'b0, NO_RESULT},
        '{KEEP, KEEP, '{fmtgt_pkg::FUNC_LOOKUP, 8'hAA, 5'h15, 5'h0A, 8'h55, 5'h0F},
          1'b0, NO_RESULT},
        // Three entries: hits deeper in the table and a miss over all three.
        '{3, 0, '{fmtgt_pkg::FUNC_LOOKUP, 8'h00, 5'h00, 5'h00, 8'h00, 5'h00},
          1'b0, NO_RESULT},
        '{KEEP, KEEP, '{fmtgt_pkg::FUNC_LOOKUP, 8'h00, 5'h00, 5'h00, 8'h00, 5'h10},
          1'b0, NO_RESULT},
        '{KEEP, KEEP, '{fmtgt_pkg::FUNC_LOOKUP, 8'h00, 5'h00, 5'h00, 8'h00, 5'h01},
          1'b0, NO_RESULT},
        // Four entries: the catch-all answers, then it is overwritten.
        '{4, 90, '{fmtgt_pkg::FUNC_LOOKUP, 8'h00, 5'h00, 5'h00, 8'h00, 5'h01},
          1'b0, NO_RESULT},
        '{KEEP, KEEP, '{fmtgt_pkg::FUNC_WRITE, 8'h03, 5'h1F, 5'h15, 8'h77, 5'h00},
          1'b0, NO_RESULT},
        '{KEEP, KEEP, '{fmtgt_pkg::FUNC_LOOKUP, 8'h00, 5'h00, 5'h00, 8'h00, 5'h05},
          1'b0, NO_RESULT},
        // No entries in use: only the fallback can answer.
        '{0, 129, '{fmtgt_pkg::FUNC_LOOKUP, 8'h00, 5'h00, 5'h00, 8'h00, 5'h1F},
          1'b1, '{8'h81, 1'b1, 11'd1}}
    };

    logic                                clk          = 1'b0;
    logic                                rst_n        = 1'b0;
    logic                                item_valid   = 1'b0;
    logic                                item_stall;
    fmtgt_pkg::item_t                    item         = '0;
    logic                                result_valid;
    logic                                result_stall = 1'b0;
    fmtgt_pkg::result_t                  result;
    logic                                psel         = 1'b0;
    logic                                penable      = 1'b0;
    logic                                pwrite       = 1'b0;
    logic [fmtgt_pkg::PADDR_W-1:0]       paddr        = '0;
    logic [fmtgt_pkg::DATA_W-1:0]        pwdata       = '0;
    logic [fmtgt_pkg::DATA_W-1:0]        prdata;
    logic                                pready;

    // Shadow of the table and the registers, kept in step with accepted words.
    logic [fmtgt_pkg::KEY_BITS-1:0]  rule_mask    [fmtgt_pkg::MAX_ENTRIES];
    logic [fmtgt_pkg::KEY_BITS-1:0]  rule_vals    [fmtgt_pkg::MAX_ENTRIES];
    logic [fmtgt_pkg::VARIANT_W-1:0] rule_variant [fmtgt_pkg::MAX_ENTRIES];
    logic [8:0]                      live_count   = '0;
    logic [fmtgt_pkg::VARIANT_W-1:0] miss_variant = '0;

    fmtgt_pkg::result_t pending_results [$];
    int                 fault_count = 0;
    int                 words_sent  = 0;

    // A stretch of words during which neither side idles.
    wire steady = (words_sent >= 700) && (words_sent < 1000);

    first_match_ternary_guard_table_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #1 clk = ~clk;

    // Scan the shadow table in priority order and work out the answer and its cost.
    function automatic fmtgt_pkg::result_t resolve_key(
        input logic [fmtgt_pkg::KEY_BITS-1:0] key);
        fmtgt_pkg::result_t r;
        int                 spent;
        int                 n;
        int                 i;
        int                 d;
        bit                 hit;
        bit                 halted;
        spent = 0;
        n = (int'(live_count) > fmtgt_pkg::MAX_ENTRIES) ?
            fmtgt_pkg::MAX_ENTRIES : int'(live_count);
        for (i = 0; i < n; i++)
        begin
            spent += 1;
            hit    = 1'b1;
            halted = 1'b0;
            for (d = 0; d < fmtgt_pkg::KEY_BITS; d++)
            begin
                if (!halted && rule_mask[i][d])
                begin
                    spent += 1;
                    if (key[d] != rule_vals[i][d])
                    begin
                        hit    = 1'b0;
                        halted = 1'b1;
                    end
                end
            end
            if (hit)
            begin
                r.chosen_variant = rule_variant[i];
                r.used_fallback  = 1'b0;
                r.step_cost      = fmtgt_pkg::COST_W'(spent);
                return r;
            end
        end
        r.chosen_variant = miss_variant;
        r.used_fallback  = 1'b1;
        r.step_cost      = fmtgt_pkg::COST_W'(spent + 1);
        return r;
    endfunction

    // Offer one word, idling now and then, and record its effect once accepted.
    task automatic send_word(input fmtgt_pkg::item_t w, input bit known,
                             input fmtgt_pkg::result_t typed);
        fmtgt_pkg::result_t due;
        while (!steady && $urandom_range(99) < 17)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        @(posedge clk);
        while (item_stall !== 1'b0)
            @(posedge clk);
        words_sent++;
        if (w.func == fmtgt_pkg::FUNC_WRITE)
        begin
            if (int'(w.entry_index) < fmtgt_pkg::MAX_ENTRIES)
            begin
                rule_mask[w.entry_index]    = w.care_mask;
                rule_vals[w.entry_index]    = w.care_values;
                rule_variant[w.entry_index] = w.entry_variant;
            end
        end
        else
        begin
            due             = known ? typed : resolve_key(w.fact_key);
            pending_results = {pending_results, due};
        end
    endtask

    // Stop sending, wait for every answer, then let any trailing write finish.
    task automatic settle_block();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One bus transfer; a read is checked against the value given.
    task automatic bus_transfer(input logic reg_sel, input logic wr,
                                input logic [fmtgt_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= wr ? value : '0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (!wr && prdata !== value)
        begin
            $display("%0t: register %0d read expected %0h, got %0h",
                     $time, reg_sel, value, prdata);
            fault_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write a register, follow it in the shadow copy and read it back.
    task automatic set_register(input logic reg_sel, input int value);
        logic [fmtgt_pkg::DATA_W-1:0] kept;
        if (reg_sel == fmtgt_pkg::CFG_ENTRY_COUNT)
        begin
            live_count = 9'(value);
            kept       = fmtgt_pkg::DATA_W'(live_count);
        end
        else
        begin
            miss_variant = fmtgt_pkg::VARIANT_W'(value);
            kept         = fmtgt_pkg::DATA_W'(miss_variant);
        end
        bus_transfer(reg_sel, 1'b1, fmtgt_pkg::DATA_W'(value));
        bus_transfer(reg_sel, 1'b0, kept);
    endtask

    // The receiving side stalls at random, except during the steady stretch.
    always @(posedge clk)
    begin
        result_stall <= !steady && ($urandom_range(99) < 17);
    end

    // Compare each accepted answer with the oldest one predicted.
    always @(posedge clk)
    begin : watch_results
        fmtgt_pkg::result_t want;
        if (rst_n && result_valid === 1'b1 && result_stall == 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word with none expected, got %0h", $time, result);
                fault_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.chosen_variant !== want.chosen_variant)
                begin
                    $display("%0t: chosen_variant expected %0h, got %0h",
                             $time, want.chosen_variant, result.chosen_variant);
                    fault_count++;
                end
                if (result.used_fallback !== want.used_fallback)
                begin
                    $display("%0t: used_fallback expected %0b, got %0b",
                             $time, want.used_fallback, result.used_fallback);
                    fault_count++;
                end
                if (result.step_cost !== want.step_cost)
                begin
                    $display("%0t: step_cost expected %0d, got %0d",
                             $time, want.step_cost, result.step_cost);
                    fault_count++;
                end
            end
        end
    end

    initial
    begin
        fmtgt_pkg::item_t w;
        int               p;
        int               k;
        int               n_count;
        int               n_miss;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words, with register changes made only while idle.
        for (k = 0; k < PROBE_ROWS; k++)
        begin
            if (PROBES[k].new_count != KEEP || PROBES[k].new_miss != KEEP)
            begin
                settle_block();
                if (PROBES[k].new_count != KEEP)
                    set_register(fmtgt_pkg::CFG_ENTRY_COUNT, PROBES[k].new_count);
                if (PROBES[k].new_miss != KEEP)
                    set_register(fmtgt_pkg::CFG_FALLBACK, PROBES[k].new_miss);
            end
            send_word(PROBES[k].word, PROBES[k].known, PROBES[k].answer);
        end

        // Fill every slot with an exact-match entry; no entry expects key zero.
        for (k = 0; k < fmtgt_pkg::MAX_ENTRIES; k++)
        begin
            w               = fmtgt_pkg::item_t'($urandom);
            w.func          = fmtgt_pkg::FUNC_WRITE;
            w.entry_index   = 8'(k);
            w.care_mask     = '1;
            w.care_values   = fmtgt_pkg::KEY_BITS'($urandom_range(1, 31));
            send_word(w, 1'b0, NO_RESULT);
        end

        // Count beyond the table: key zero walks all entries and falls back.
        settle_block();
        set_register(fmtgt_pkg::CFG_ENTRY_COUNT, 511);
        set_register(fmtgt_pkg::CFG_FALLBACK, 255);
        for (k = 0; k < DEEP_WORDS; k++)
        begin
            w      = fmtgt_pkg::item_t'($urandom);
            w.func = fmtgt_pkg::FUNC_LOOKUP;
            if (k % 2 == 0)
                w.fact_key = '0;
            send_word(w, 1'b0, NO_RESULT);
        end

        // Random phases, each under its own register settings.
        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       n_count = fmtgt_pkg::MAX_ENTRIES;
                1:       n_count = 0;
                2:       n_count = 1;
                3:       n_count = $urandom_range(fmtgt_pkg::MAX_ENTRIES + 1, 510);
                4:       n_count = 511;
                default: n_count = ($urandom_range(3) == 0) ?
                                   $urandom_range(17, fmtgt_pkg::MAX_ENTRIES) :
                                   $urandom_range(2, 16);
            endcase
            n_miss = (p == 0) ? 0 : (p == 1) ? 255 : $urandom_range(255);
            settle_block();
            set_register(fmtgt_pkg::CFG_ENTRY_COUNT, n_count);
            set_register(fmtgt_pkg::CFG_FALLBACK, n_miss);
            for (k = 0; k < PHASE_WORDS; k++)
            begin
                w = fmtgt_pkg::item_t'($urandom);
                if ($urandom_range(99) < 40)
                begin
                    w.func = fmtgt_pkg::FUNC_WRITE;
                    // Half the writes are exact entries, which match rarely.
                    if ($urandom_range(1) == 1)
                        w.care_mask = '1;
                end
                else
                begin
                    w.func = fmtgt_pkg::FUNC_LOOKUP;
                end
                send_word(w, 1'b0, NO_RESULT);
            end
        end

        settle_block();
        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #6_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
